// ===== sv/btlr_pkg.sv =====
// shared types and codes for the thick line rasteriser
package btlr_pkg;

  // request kinds carried on s_tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd480;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWAP,
    ST_DX,
    ST_DY,
    ST_ADY,
    ST_MAJ,
    ST_EMIT,
    ST_ERR_ADD,
    ST_ERR_CHK,
    ST_ERR_SUB,
    ST_MINOR,
    ST_MAJOR
  } state_t;

endpackage

// ===== sv/btlr_alu.sv =====
// shared add/subtract unit with sign flag
module btlr_alu import btlr_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  alu_op_t          op,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] sum,
  output logic             negative
);

  assign sum      = (op == ALU_SUB) ? (a - b) : (a + b);
  assign negative = sum[WIDTH-1];

endmodule

// ===== sv/bresenham_thick_line_raster.sv =====
// top level of the thick line rasteriser: sequencer, line state and output register
// Usage
//   s_* channel takes requests: s_tuser = command (start or step), s_tdata = endpoints,
//   both colours and thickness. A start request loads a line and returns no pixel; a
//   step request returns line_thickness pixels, clamped to 1..min(MAX_THICKNESS, 16)
//   (centre first, then minor-axis offsets), or nothing when no line is active.
//   m_* channel gives one pixel per transfer; m_tlast marks the final pixel of a step,
//   m_tuser carries visibility and the line-done flag.
//   APB port: frame_width at 0x0, frame_height at 0x4 (12 bits), used for visibility.
// Timing
//   every value is formed by one shared adder/subtractor driven by the sequencer
//   start request: SWAP, DX, DY, ADY and MAJ run before s_tready rises again
//   step request: EMIT hands out the pixels; ERR_ADD, ERR_CHK, ERR_SUB, MINOR, MAJOR
//   update the error (ERR_SUB and MINOR only when the minor coordinate moves); the step
//   at the end point has no update; one pixel per cycle while m_tready stays high
// Reset and stalls
//   rst clears the sequencer, drops any line in progress and restores 640 x 480
//   a low m_tready freezes pixel generation; the pending pixel is held in the output
//   register, and a new request is taken while the last pixel of a step still waits
module bresenham_thick_line_raster import btlr_pkg::*; #(
  parameter int COORD_BITS    = 12,
  parameter int MAX_THICKNESS = 16,
  localparam int IN_W  = ((4 * COORD_BITS + 69 + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 32 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             s_tvalid,
  output logic             s_tready,
  // start_x, start_y, end_x, end_y, colour_a, colour_b, line_thickness, pad
  input  logic [IN_W-1:0]  s_tdata,
  // command
  input  logic             s_tuser,
  // pixel channel
  output logic             m_tvalid,
  input  logic             m_tready,
  // pixel_x, pixel_y, pixel_colour, pad
  output logic [OUT_W-1:0] m_tdata,
  // visible, line_done
  output logic [1:0]       m_tuser,
  output logic             m_tlast,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int C   = COORD_BITS;
  localparam int W   = COORD_BITS + 4;            // adder width, holds twice the error
  localparam int CAP = (MAX_THICKNESS < 16) ? MAX_THICKNESS : 16;
  localparam int TW  = $clog2(CAP + 1);
  localparam int OFW = TW + 1;                    // signed minor offset
  localparam int VW  = (COORD_BITS > 12) ? COORD_BITS : 12;

  // configuration registers
  logic [11:0] frame_width;
  logic [11:0] frame_height;

  // sequencer
  state_t state, state_next;

  // captured start request
  logic [C-1:0] in_ax, in_ay, in_bx, in_by;
  logic [31:0]  in_ca, in_cb;
  logic         swap;
  logic         dy_neg;
  logic [W-1:0] dx;
  logic [W-1:0] dy;

  // line state
  logic          line_active;
  logic [C-1:0]  major_pos;
  logic [C-1:0]  minor_pos;
  logic [C-1:0]  major_end;
  logic [C:0]    major_delta;
  logic [C:0]    minor_delta;
  logic [W-1:0]  error_term;
  logic          y_is_major;
  logic          minor_step_negative;
  logic          major_step_negative;
  logic [31:0]   line_colour;
  logic [TW-1:0] stored_thickness;

  // pixel walk across the line
  logic [TW-1:0]  k;
  logic [OFW-1:0] off;
  logic [OFW-1:0] off_next;
  logic [OFW-1:0] step_up;

  // output register
  logic [C-1:0] px_q, py_q;
  logic [31:0]  col_q;
  logic         vis_q, last_q, done_q;

  // shared unit
  alu_op_t      alu_op;
  logic [W-1:0] alu_a, alu_b, alu_sum;
  logic         alu_neg;

  btlr_alu #(.WIDTH(W)) u_alu (
    .op       (alu_op),
    .a        (alu_a),
    .b        (alu_b),
    .sum      (alu_sum),
    .negative (alu_neg)
  );

  // request fields
  logic          accept;
  logic [4:0]    t_raw;
  logic [4:0]    t_nz;
  logic [TW-1:0] t_clamped;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign t_raw    = s_tdata[4*C+68:4*C+64];
  assign t_nz     = (t_raw == 5'd0) ? 5'd1 : t_raw;
  assign t_clamped = (t_nz > 5'(CAP)) ? TW'(CAP) : TW'(t_nz);

  // sign-extended operands
  logic [W-1:0] ax_w, ay_w, bx_w, by_w, minor_w, major_w, off_w;
  assign ax_w    = {{(W-C){in_ax[C-1]}}, in_ax};
  assign ay_w    = {{(W-C){in_ay[C-1]}}, in_ay};
  assign bx_w    = {{(W-C){in_bx[C-1]}}, in_bx};
  assign by_w    = {{(W-C){in_by[C-1]}}, in_by};
  assign minor_w = {{(W-C){minor_pos[C-1]}}, minor_pos};
  assign major_w = {{(W-C){major_pos[C-1]}}, major_pos};
  assign off_w   = {{(W-OFW){off[OFW-1]}}, off};

  // step bookkeeping
  logic [TW-1:0] up;
  logic          last_px;
  logic          done_now;
  logic          out_free;

  assign up       = stored_thickness >> 1;           // offsets on the minor step side
  assign last_px  = (k == (stored_thickness - TW'(1)));
  assign done_now = (major_pos == major_end);
  assign out_free = !m_tvalid || m_tready;

  // +1 in the minor step direction, then the far side
  assign step_up = minor_step_negative ? {OFW{1'b1}} : OFW'(1);
  always_comb begin
    if (k < up) begin
      off_next = off + step_up;
    end else if (k == up) begin
      off_next = OFW'(0) - step_up;
    end else begin
      off_next = off - step_up;
    end
  end

  // pixel under construction
  logic [C-1:0] mn;
  logic [C-1:0] px, py;
  logic         vis;
  assign mn  = alu_sum[C-1:0];                      // wraps within the coordinate width
  assign px  = y_is_major ? mn : major_pos;
  assign py  = y_is_major ? major_pos : mn;
  assign vis = !px[C-1] && !py[C-1] &&
               (VW'(px) < VW'(frame_width)) && (VW'(py) < VW'(frame_height));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == CMD_START) begin
            state_next = ST_SWAP;
          end else if (line_active) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SWAP:    state_next = ST_DX;
      ST_DX:      state_next = ST_DY;
      ST_DY:      state_next = ST_ADY;
      ST_ADY:     state_next = ST_MAJ;
      ST_MAJ:     state_next = ST_IDLE;
      ST_EMIT: begin
        if (out_free && last_px) begin
          state_next = done_now ? ST_IDLE : ST_ERR_ADD;
        end
      end
      ST_ERR_ADD: state_next = ST_ERR_CHK;
      ST_ERR_CHK: state_next = alu_neg ? ST_MAJOR : ST_ERR_SUB;
      ST_ERR_SUB: state_next = ST_MINOR;
      ST_MINOR:   state_next = ST_MAJOR;
      ST_MAJOR:   state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      ST_SWAP: begin
        alu_op = ALU_SUB;
        alu_a  = bx_w;
        alu_b  = ax_w;
      end
      ST_DX: begin
        alu_op = ALU_SUB;
        alu_a  = swap ? ax_w : bx_w;
        alu_b  = swap ? bx_w : ax_w;
      end
      ST_DY: begin
        alu_op = ALU_SUB;
        alu_a  = swap ? ay_w : by_w;
        alu_b  = swap ? by_w : ay_w;
      end
      ST_ADY: begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = dy;
      end
      ST_MAJ: begin
        alu_op = ALU_SUB;
        alu_a  = dx;
        alu_b  = dy;
      end
      ST_EMIT: begin
        alu_a = minor_w;
        alu_b = off_w;
      end
      ST_ERR_ADD: begin
        alu_a = error_term;
        alu_b = W'(minor_delta);
      end
      ST_ERR_CHK: begin
        alu_op = ALU_SUB;
        alu_a  = {error_term[W-2:0], 1'b0};
        alu_b  = W'(major_delta);
      end
      ST_ERR_SUB: begin
        alu_op = ALU_SUB;
        alu_a  = error_term;
        alu_b  = W'(major_delta);
      end
      ST_MINOR: begin
        alu_a = minor_w;
        alu_b = minor_step_negative ? {W{1'b1}} : W'(1);
      end
      ST_MAJOR: begin
        alu_a = major_w;
        alu_b = major_step_negative ? {W{1'b1}} : W'(1);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // sequencer and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      line_active         <= 1'b0;
      major_pos           <= '0;
      minor_pos           <= '0;
      major_end           <= '0;
      major_delta         <= '0;
      minor_delta         <= '0;
      error_term          <= '0;
      y_is_major          <= 1'b0;
      minor_step_negative <= 1'b0;
      major_step_negative <= 1'b0;
      line_colour         <= '0;
      stored_thickness    <= TW'(1);
      k                   <= '0;
      off                 <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            k   <= '0;
            off <= '0;
            if (s_tuser == CMD_START) begin
              stored_thickness <= t_clamped;
            end
          end
        end
        ST_MAJ: begin
          // alu_neg here means the y extent exceeds the x extent
          y_is_major  <= alu_neg;
          error_term  <= '0;
          line_active <= 1'b1;
          line_colour <= swap ? in_cb : in_ca;
          if (alu_neg) begin
            major_pos           <= swap ? in_by : in_ay;
            major_end           <= swap ? in_ay : in_by;
            major_step_negative <= dy_neg;
            minor_pos           <= swap ? in_bx : in_ax;
            minor_step_negative <= 1'b0;
            major_delta         <= dy[C:0];
            minor_delta         <= dx[C:0];
          end else begin
            major_pos           <= swap ? in_bx : in_ax;
            major_end           <= swap ? in_ax : in_bx;
            major_step_negative <= 1'b0;
            minor_pos           <= swap ? in_by : in_ay;
            minor_step_negative <= dy_neg;
            major_delta         <= dx[C:0];
            minor_delta         <= dy[C:0];
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            k   <= k + TW'(1);
            off <= off_next;
            if (last_px && done_now) begin
              line_active <= 1'b0;
            end
          end
        end
        ST_ERR_ADD: error_term <= alu_sum;
        ST_ERR_SUB: error_term <= alu_sum;
        ST_MINOR:   minor_pos  <= alu_sum[C-1:0];
        ST_MAJOR:   major_pos  <= alu_sum[C-1:0];
        default: begin
        end
      endcase
    end
  end

  // start request capture and set-up results
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == CMD_START)) begin
      in_ax <= s_tdata[C-1:0];
      in_ay <= s_tdata[2*C-1:C];
      in_bx <= s_tdata[3*C-1:2*C];
      in_by <= s_tdata[4*C-1:3*C];
      in_ca <= s_tdata[4*C+31:4*C];
      in_cb <= s_tdata[4*C+63:4*C+32];
    end
    case (state)
      ST_SWAP: swap <= alu_neg;                     // second endpoint has the smaller x
      ST_DX:   dx   <= alu_sum;
      ST_DY:   dy   <= alu_sum;
      ST_ADY: begin
        dy_neg <= dy[W-1];
        if (dy[W-1]) begin
          dy <= alu_sum;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      px_q   <= px;
      py_q   <= py;
      col_q  <= line_colour;
      vis_q  <= vis;
      last_q <= last_px;
      done_q <= done_now;
    end
  end

  assign m_tdata = OUT_W'({col_q, py_q, px_q});
  assign m_tuser = {done_q, vis_q};
  assign m_tlast = last_q;

  // configuration port
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_FRAME_WIDTH) begin
        frame_width <= pwdata[11:0];
      end else begin
        frame_height <= pwdata[11:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? {20'd0, frame_height}
                                                 : {20'd0, frame_width};

`ifndef SYNTH
  // pixels are only generated for a loaded line
  a_emit_needs_line: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> line_active)
    else $error("pixel generation without an active line");

  // the walk across the line never passes the stored thickness
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (k < stored_thickness))
    else $error("pixel count beyond thickness");

  // a start request has the line loaded after the set-up sequence
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser == CMD_START)) |-> ##6 (line_active && s_tready))
    else $error("start request did not load a line");

  // the end-point step ends the line without an error update
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && out_free && last_px && done_now) |=>
      (!line_active && (state == ST_IDLE)))
    else $error("line still active after its final step");
`endif

endmodule
